[src/gmat_pkg.sv]
// gmat_pkg: opcodes, glob constants, control struct and case folding
// shared by the glob matcher cells and the top level; no dependencies
package gmat_pkg;

  // input opcodes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       accept;
    op_e        op;
    logic [7:0] chr;     // case-folded byte of the item
  } ctrl_t;

  // fold ascii A-Z to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

[src/gmat_prefix.sv]
// gmat_prefix: log-depth star closure over all pattern positions
// (generate/propagate prefix network); no package dependencies
module gmat_prefix #(
  parameter int N = 257
) (
  input  logic [N-1:0] gen_i,
  input  logic [N-1:0] prop_i,
  output logic [N-1:0] closed_o
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] g_lv [LEVELS+1];
  logic [N-1:0] p_lv [LEVELS];

  assign g_lv[0] = gen_i;
  assign p_lv[0] = prop_i;

  // each level doubles the reach of a star run
  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    localparam int D = 1 << k;
    for (genvar j = 0; j < N; j++) begin : g_bit
      if (j >= D) begin : g_comb
        assign g_lv[k+1][j] = g_lv[k][j] | (p_lv[k][j] & g_lv[k][j-D]);
        if (k + 1 < LEVELS) begin : g_p
          assign p_lv[k+1][j] = p_lv[k][j] & p_lv[k][j-D];
        end
      end else begin : g_pass
        assign g_lv[k+1][j] = g_lv[k][j];
        if (k + 1 < LEVELS) begin : g_p
          assign p_lv[k+1][j] = p_lv[k][j];
        end
      end
    end
  end

  assign closed_o = g_lv[LEVELS];

endmodule

[src/gmat_cell.sv]
// gmat_cell: one pattern position; holds its byte, in-use bit and active bit
// depends on gmat_pkg
module gmat_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gmat_pkg::ctrl_t ctrl_i,
  input  logic            prev_used_i,
  input  logic            prev_active_i,
  input  logic            closed_i,
  output logic            used_o,
  output logic            active_o,
  output logic            gen_o,
  output logic            prop_o
);

  logic       used_q, used_d;
  logic       active_q, active_d;
  logic       star_q, qm_q;
  logic [7:0] chr_q;
  logic       write_here;
  logic       hit;

  // first free cell takes an appended byte
  assign write_here = ctrl_i.accept && (ctrl_i.op == gmat_pkg::OP_APPEND)
                      && !used_q && prev_used_i;

  assign hit = qm_q || (chr_q == ctrl_i.chr);

  // closure inputs: free cells copy their predecessor, except the one taking an appended byte
  always_comb begin
    gen_o = 1'b0;
    case (ctrl_i.op)
      gmat_pkg::OP_CLEAR:  gen_o = 1'b0;
      gmat_pkg::OP_APPEND: gen_o = used_q & active_q;
      gmat_pkg::OP_TEXT:   gen_o = used_q & (star_q ? active_q : (hit & prev_active_i));
      gmat_pkg::OP_END:    gen_o = 1'b0;
      default:             gen_o = 1'b0;
    endcase
    if (ctrl_i.op == gmat_pkg::OP_CLEAR) begin
      prop_o = 1'b1;
    end else if (write_here) begin
      prop_o = (ctrl_i.chr == gmat_pkg::CH_STAR);
    end else begin
      prop_o = !used_q || star_q;
    end
  end

  // next control state
  always_comb begin
    used_d   = used_q;
    active_d = active_q;
    if (ctrl_i.accept) begin
      active_d = closed_i;
      if (ctrl_i.op == gmat_pkg::OP_CLEAR) begin
        used_d = 1'b0;
      end else if (write_here) begin
        used_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= 1'b0;
      active_q <= 1'b1;
    end else begin
      used_q   <= used_d;
      active_q <= active_d;
    end
  end

  // pattern byte, stored folded with its wildcard flags
  always_ff @(posedge clk_i) begin
    if (write_here) begin
      chr_q  <= ctrl_i.chr;
      star_q <= (ctrl_i.chr == gmat_pkg::CH_STAR);
      qm_q   <= (ctrl_i.chr == gmat_pkg::CH_QMARK);
    end
  end

  assign used_o   = used_q;
  assign active_o = active_q;

endmodule

[src/wildcard_glob_matcher.sv]
// wildcard_glob_matcher: streamed glob match over a row of pattern cells
// depends on gmat_pkg, gmat_cell and gmat_prefix
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, opcode_i, character_i | sink
//  out     | out_valid_o, out_stall_i, matched_o, pattern_overflow_o | source
//
// one item is accepted per cycle while the input is not stalled; the cell
// update is registered and the star closure network is combinational
// an end-of-text item shows its result in the cycle after acceptance
// input stalls only while a result is held and the output is stalled
// reset empties the pattern and clears the overflow flag; no clearing pass
module wildcard_glob_matcher #(
  parameter int MAX_PATTERN = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] character_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       pattern_overflow_o
);

  localparam int NPOS = MAX_PATTERN + 1;

  gmat_pkg::ctrl_t ctrl;
  logic            in_acc;
  logic [NPOS-1:0] used_w, act_w, gen_w, prop_w, closed_w;
  logic            start_gen;
  logic            act0_q, act0_d;
  logic            ovf_q, ovf_d;
  logic            out_valid_q, out_valid_d;
  logic            matched_q, ovf_out_q;
  logic            end_acc;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ctrl.accept = in_acc;
  assign ctrl.op     = gmat_pkg::op_e'(opcode_i);
  assign ctrl.chr    = gmat_pkg::fold_case(character_i);

  assign end_acc = in_acc && (ctrl.op == gmat_pkg::OP_END);

  // position zero: start of text
  assign used_w[0] = 1'b1;
  assign act_w[0]  = act0_q;
  assign prop_w[0] = 1'b0;
  assign gen_w[0]  = start_gen;

  always_comb begin
    start_gen = act0_q;
    case (ctrl.op)
      gmat_pkg::OP_CLEAR:  start_gen = 1'b1;
      gmat_pkg::OP_APPEND: start_gen = act0_q;
      gmat_pkg::OP_TEXT:   start_gen = 1'b0;
      gmat_pkg::OP_END:    start_gen = 1'b1;
      default:             start_gen = act0_q;
    endcase
  end

  // row of pattern cells
  for (genvar i = 1; i < NPOS; i++) begin : g_cell
    gmat_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .prev_used_i   (used_w[i-1]),
      .prev_active_i (act_w[i-1]),
      .closed_i      (closed_w[i]),
      .used_o        (used_w[i]),
      .active_o      (act_w[i]),
      .gen_o         (gen_w[i]),
      .prop_o        (prop_w[i])
    );
  end

  // star closure over all positions
  gmat_prefix #(
    .N (NPOS)
  ) u_prefix (
    .gen_i    (gen_w),
    .prop_i   (prop_w),
    .closed_o (closed_w)
  );

  // position zero and overflow flag
  always_comb begin
    act0_d = act0_q;
    ovf_d  = ovf_q;
    if (in_acc) begin
      act0_d = closed_w[0];
      if (ctrl.op == gmat_pkg::OP_CLEAR) begin
        ovf_d = 1'b0;
      end else if (ctrl.op == gmat_pkg::OP_APPEND && used_w[NPOS-1]) begin
        ovf_d = 1'b1;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (end_acc) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act0_q      <= 1'b1;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      act0_q      <= act0_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result of the finished text; free cells mirror the last position
  always_ff @(posedge clk_i) begin
    if (end_acc) begin
      matched_q <= act_w[NPOS-1] && !ovf_q;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = ovf_out_q;

  // overflow only happens with a full store
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> used_w[NPOS-1])
    else $error("overflow flag set while pattern store not full");

  // in-use bits fill from position one upward
  a_used_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((used_w >> 1) & ~used_w) == '0)
    else $error("pattern cells not filled in order");

  // an accepted end of text always yields a result
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_acc |=> out_valid_q)
    else $error("end of text item produced no result");

  // a clear leaves an empty pattern that matches the empty text
  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ctrl.op == gmat_pkg::OP_CLEAR)
      |=> (act_w[NPOS-1] && !ovf_q && !used_w[1]))
    else $error("clear did not restore the empty pattern");

  // stall only while a held result waits
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with no pending result");

  // a stalled result holds its value
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i)
      |=> (out_valid_q && $stable(matched_q) && $stable(ovf_out_q)))
    else $error("stalled result changed");

endmodule

[tb/wildcard_glob_matcher_tb.sv]
// wildcard_glob_matcher_tb: drives opcode/character items into the glob matcher,
// tracks the active-position automaton in a local shadow and checks each verdict
// depends on gmat_pkg and wildcard_glob_matcher
module wildcard_glob_matcher_tb;

  localparam int MAX_PAT        = 256;
  localparam int WATCHDOG_LIMIT = 2000;

  // expected outcome of one end-of-text item
  typedef struct packed {
    logic matched;
    logic ovf;
  } verdict_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] opcode_i;
  logic [7:0] character_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       matched_o;
  logic       pattern_overflow_o;

  // shadow of the pattern store and automaton
  logic [7:0]       shadow_pat [MAX_PAT];
  int unsigned      shadow_len;
  logic [MAX_PAT:0] shadow_live;
  logic             shadow_ovf;

  verdict_t verdict_q [$];
  verdict_t head;
  int       fail_cnt     = 0;
  int       items_sent   = 0;
  int       quiet_cycles = 0;
  bit       idle_on      = 1'b1;

  wildcard_glob_matcher #(
    .MAX_PATTERN(MAX_PAT)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .character_i       (character_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .matched_o         (matched_o),
    .pattern_overflow_o(pattern_overflow_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ascii A-Z folds to lower case, everything else passes
  function automatic logic [7:0] lower_az(input logic [7:0] c);
    return (c >= gmat_pkg::CH_UPPER_A && c <= gmat_pkg::CH_UPPER_Z)
           ? c + gmat_pkg::CASE_OFFSET : c;
  endfunction

  // a position after a star is live whenever the star's position is live
  function automatic void close_stars();
    for (int i = 1; i <= shadow_len; i++) begin
      if (shadow_pat[i-1] == gmat_pkg::CH_STAR && shadow_live[i-1]) begin
        shadow_live[i] = 1'b1;
      end
    end
  endfunction

  function automatic void restart_text();
    shadow_live    = '0;
    shadow_live[0] = 1'b1;
    close_stars();
  endfunction

  // advance every position by one text byte
  function automatic void consume_text(input logic [7:0] c);
    logic [MAX_PAT:0] nxt;
    logic [7:0]       t;
    logic [7:0]       p;
    nxt = '0;
    t   = lower_az(c);
    for (int i = 1; i <= shadow_len; i++) begin
      p = shadow_pat[i-1];
      if (p == gmat_pkg::CH_STAR) begin
        nxt[i] = shadow_live[i];
      end else if (p == gmat_pkg::CH_QMARK || lower_az(p) == t) begin
        nxt[i] = shadow_live[i-1];
      end
    end
    shadow_live = nxt;
    close_stars();
  endfunction

  // update the shadow for one accepted item, queue a verdict on end of text
  function automatic void track_item(input gmat_pkg::op_e op, input logic [7:0] ch);
    verdict_t v;
    case (op)
      gmat_pkg::OP_CLEAR: begin
        shadow_len = 0;
        shadow_ovf = 1'b0;
        restart_text();
      end
      gmat_pkg::OP_APPEND: begin
        if (shadow_len < MAX_PAT) begin
          shadow_pat[shadow_len]  = ch;
          shadow_len++;
          shadow_live[shadow_len] = (ch == gmat_pkg::CH_STAR) && shadow_live[shadow_len-1];
        end else begin
          shadow_ovf = 1'b1;
        end
      end
      gmat_pkg::OP_TEXT: begin
        consume_text(ch);
      end
      default: begin
        v.matched = shadow_live[shadow_len] && !shadow_ovf;
        v.ovf     = shadow_ovf;
        verdict_q = {verdict_q, v};
        restart_text();
      end
    endcase
  endfunction

  // send one item, with an optional idle burst ahead of it
  task automatic send_item(input gmat_pkg::op_e op, input logic [7:0] ch);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    character_i <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_item(op, ch);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_str(input gmat_pkg::op_e op, input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(op, s[i]);
    end
  endtask

  // hold the input until every queued verdict has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_text_char();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 0) c = c - 8'h20;
    if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] pick_pat_char();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = gmat_pkg::CH_STAR;
      1:       c = gmat_pkg::CH_QMARK;
      default: c = pick_text_char();
    endcase
    return c;
  endfunction

  // one pattern and a few texts against it, sometimes cut short
  task automatic run_session();
    int plen;
    int ntext;
    int tlen;
    plen  = $urandom_range(0, 8);
    ntext = $urandom_range(1, 4);
    if ($urandom_range(0, 9) != 0) send_item(gmat_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
    repeat (plen) send_item(gmat_pkg::OP_APPEND, pick_pat_char());
    repeat (ntext) begin
      tlen = $urandom_range(0, 10);
      repeat (tlen) begin
        if ($urandom_range(0, 15) == 0) send_item(gmat_pkg::OP_APPEND, pick_pat_char());
        send_item(gmat_pkg::OP_TEXT, pick_text_char());
      end
      if ($urandom_range(0, 11) != 0) send_item(gmat_pkg::OP_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // empty pattern, ignored character on clear and end
  task automatic test_empty_pattern();
    send_item(gmat_pkg::OP_CLEAR, 8'hFF);
    send_item(gmat_pkg::OP_END, 8'hA5);
    send_item(gmat_pkg::OP_TEXT, "a");
    send_item(gmat_pkg::OP_END, 8'h00);
  endtask

  // star and question mark, upper case against lower case
  task automatic test_wildcards();
    send_item(gmat_pkg::OP_CLEAR, 8'h00);
    send_str(gmat_pkg::OP_APPEND, "a*?Z");
    send_str(gmat_pkg::OP_TEXT, "AbcZ");
    send_item(gmat_pkg::OP_END, 8'h00);
    send_str(gmat_pkg::OP_TEXT, "aZ");
    send_item(gmat_pkg::OP_END, 8'hFF);
  endtask

  // bytes just outside A-Z and the byte extremes do not fold
  task automatic test_case_fold();
    send_item(gmat_pkg::OP_CLEAR, 8'h00);
    send_item(gmat_pkg::OP_APPEND, 8'h40);
    send_item(gmat_pkg::OP_APPEND, 8'h5B);
    send_item(gmat_pkg::OP_APPEND, 8'hFF);
    send_item(gmat_pkg::OP_APPEND, 8'h00);
    send_item(gmat_pkg::OP_TEXT, 8'h60);
    send_item(gmat_pkg::OP_TEXT, 8'h7B);
    send_item(gmat_pkg::OP_TEXT, 8'hFF);
    send_item(gmat_pkg::OP_TEXT, 8'h00);
    send_item(gmat_pkg::OP_END, 8'h00);
    send_item(gmat_pkg::OP_TEXT, 8'h40);
    send_item(gmat_pkg::OP_TEXT, 8'h5B);
    send_item(gmat_pkg::OP_TEXT, 8'hFF);
    send_item(gmat_pkg::OP_TEXT, 8'h00);
    send_item(gmat_pkg::OP_END, 8'h00);
  endtask

  // pattern grows while a text is under way
  task automatic test_append_mid_text();
    send_item(gmat_pkg::OP_CLEAR, 8'h00);
    send_str(gmat_pkg::OP_APPEND, "a*");
    send_item(gmat_pkg::OP_TEXT, "a");
    send_item(gmat_pkg::OP_APPEND, "b");
    send_str(gmat_pkg::OP_TEXT, "xB");
    send_item(gmat_pkg::OP_END, 8'h00);
    send_item(gmat_pkg::OP_TEXT, "a");
    send_item(gmat_pkg::OP_APPEND, "*");
    send_item(gmat_pkg::OP_END, 8'h00);
  endtask

  // full store, then overflow kept until the next clear
  task automatic test_full_store();
    wait_drained();
    send_item(gmat_pkg::OP_CLEAR, 8'h00);
    for (int i = 0; i < MAX_PAT - 1; i++) send_item(gmat_pkg::OP_APPEND, gmat_pkg::CH_STAR);
    send_item(gmat_pkg::OP_APPEND, gmat_pkg::CH_QMARK);
    send_item(gmat_pkg::OP_END, 8'h00);
    send_item(gmat_pkg::OP_TEXT, "q");
    send_item(gmat_pkg::OP_END, 8'h00);
    send_item(gmat_pkg::OP_APPEND, "x");
    send_item(gmat_pkg::OP_TEXT, "q");
    send_item(gmat_pkg::OP_END, 8'h00);
    send_item(gmat_pkg::OP_END, 8'h00);
    send_item(gmat_pkg::OP_CLEAR, 8'h00);
    send_item(gmat_pkg::OP_END, 8'h00);
  endtask

  // random sessions mixed with noise items
  task automatic test_random_sessions();
    while (items_sent < 640) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(gmat_pkg::op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        run_session();
      end
    end
  endtask

  // back-to-back items with no idling on either side
  task automatic test_steady_stream();
    int stop_at;
    stop_at = items_sent + 60;
    idle_on = 1'b0;
    while (items_sent < stop_at) run_session();
  endtask

  // output stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && rst_ni && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // compare each verdict with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected item expected none actual matched=%b overflow=%b",
                 $time, matched_o, pattern_overflow_o);
      end else begin
        head = verdict_q.pop_front();
        if (matched_o !== head.matched) begin
          fail_cnt++;
          $display("%0t: matched expected %b actual %b",
                   $time, head.matched, matched_o);
        end
        if (pattern_overflow_o !== head.ovf) begin
          fail_cnt++;
          $display("%0t: pattern_overflow expected %b actual %b",
                   $time, head.ovf, pattern_overflow_o);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout with %0d verdicts outstanding", $time, verdict_q.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, test sequence and verdict
  initial begin
    in_valid_i  = 1'b0;
    opcode_i    = gmat_pkg::OP_CLEAR;
    character_i = '0;
    rst_ni      = 1'b0;
    shadow_pat  = '{default: '0};
    shadow_len  = 0;
    shadow_ovf  = 1'b0;
    restart_text();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_pattern();
    test_wildcards();
    test_case_fold();
    test_append_mid_text();
    test_full_store();
    test_random_sessions();
    test_steady_stream();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
